@@ design/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the arp responder and address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int CMD_W = 2;
  localparam int OPC_W = 16;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // arp opcodes
  localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] OPC_REPLY   = 16'd2;

  // configuration register index
  localparam logic REG_OWN_IP = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_REPLY,
    OP_STORE,
    OP_LOOKUP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
  } op_t;

endpackage

@@ design/arp_responder_and_cache.sv @@
// Replies, stores and ignored words produce their result word from the queue
// head; a lookup scans the table from index 0 up to the fill count, one entry
// per cycle. Throughput: one non-lookup word per cycle while the output is not
// stalled; a four-word queue lets input run ahead of a long scan. Reset clears
// control state and the fill count; the table needs no clearing pass and takes
// words right after reset.
// ----------------------------------------------------------------------------
// arp_responder_and_cache
// Arp request responder with an ip-to-mac table written at a wrapping pointer
// and searched from index 0 for the first matching ip.
// ----------------------------------------------------------------------------
module arp_responder_and_cache
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [MAC_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [OPC_W-1:0]  opcode,
  input  logic [MAC_W-1:0]  sender_mac,
  input  logic [IP_W-1:0]   sender_ip,
  input  logic [IP_W-1:0]   target_ip,
  input  logic [IP_W-1:0]   table_ip,
  input  logic [MAC_W-1:0]  entry_mac,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              reply_valid,
  output logic [MAC_W-1:0]  reply_target_mac,
  output logic [IP_W-1:0]   reply_target_ip,
  output logic              lookup_hit,
  output logic [MAC_W-1:0]  lookup_mac
);

  op_t  front_op;
  op_t  q_op;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  arpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .opcode     (opcode),
    .sender_mac (sender_mac),
    .sender_ip  (sender_ip),
    .target_ip  (target_ip),
    .table_ip   (table_ip),
    .entry_mac  (entry_mac),
    .op         (front_op)
  );

  arpc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (front_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_op),
    .empty   (q_empty)
  );

  arpc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_op             (q_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .reply_valid      (reply_valid),
    .reply_target_mac (reply_target_mac),
    .reply_target_ip  (reply_target_ip),
    .lookup_hit       (lookup_hit),
    .lookup_mac       (lookup_mac)
  );

endmodule

@@ design/arpc_front.sv @@
// ----------------------------------------------------------------------------
// arpc_front
// Holds the own ip register and turns each accepted word into a table or
// reply operation for the back end.
// ----------------------------------------------------------------------------
module arpc_front
  import arpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [MAC_W-1:0]  cfg_data,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [OPC_W-1:0]  opcode,
  input  logic [MAC_W-1:0]  sender_mac,
  input  logic [IP_W-1:0]   sender_ip,
  input  logic [IP_W-1:0]   target_ip,
  input  logic [IP_W-1:0]   table_ip,
  input  logic [MAC_W-1:0]  entry_mac,
  output op_t               op
);

  logic [IP_W-1:0] own_ip;

  // own mac is not kept here
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_write && cfg_index == REG_OWN_IP) begin
      own_ip <= cfg_data[IP_W-1:0];
    end
  end

  always_comb begin
    op      = '0;
    op.kind = OP_NONE;
    unique case (cmd)
      CMD_PACKET: begin
        if (opcode == OPC_REQUEST) begin
          // unset own ip never answers
          if (own_ip != '0 && own_ip == target_ip) begin
            op.kind = OP_REPLY;
            op.ip   = sender_ip;
            op.mac  = sender_mac;
          end
        end else if (opcode == OPC_REPLY) begin
          op.kind = OP_STORE;
          op.ip   = sender_ip;
          op.mac  = sender_mac;
        end
      end
      CMD_ADD: begin
        op.kind = OP_STORE;
        op.ip   = table_ip;
        op.mac  = entry_mac;
      end
      CMD_LOOKUP: begin
        op.kind = OP_LOOKUP;
        op.ip   = table_ip;
      end
      default: begin
        op.kind = OP_NONE;
      end
    endcase
  end

endmodule

@@ design/arpc_queue.sv @@
// ----------------------------------------------------------------------------
// arpc_queue
// Short operation queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module arpc_queue
  import arpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  op_t   push_op,
  output logic  full,
  input  logic  pop,
  output op_t   pop_op,
  output logic  empty
);

  op_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full   = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

endmodule

@@ design/arpc_back.sv @@
// ----------------------------------------------------------------------------
// arpc_back
// Table engine: writes entries at the wrapping pointer, scans the table one
// entry per cycle for lookups and holds the result word.
// ----------------------------------------------------------------------------
module arpc_back
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  op_t               q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              reply_valid,
  output logic [MAC_W-1:0]  reply_target_mac,
  output logic [IP_W-1:0]   reply_target_ip,
  output logic              lookup_hit,
  output logic [MAC_W-1:0]  lookup_mac
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state;
  logic [IP_W-1:0]   entry_ips  [TABLE_DEPTH];
  logic [MAC_W-1:0]  entry_macs [TABLE_DEPTH];
  logic [IDX_W-1:0]  write_pointer;
  logic [IDX_W-1:0]  write_pointer_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  addr;
  logic              rd_pend;
  logic [IP_W-1:0]   rd_ip;
  logic [MAC_W-1:0]  rd_mac;
  logic [IP_W-1:0]   key;
  logic              res_valid;
  logic              slot_free;
  logic              hit_now;
  logic              rd_en;
  logic              wr_en;
  logic              full_table;

  assign out_valid  = res_valid;
  assign slot_free  = !res_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && !q_empty && slot_free;
  assign hit_now    = rd_pend && (rd_ip == key);
  assign rd_en      = (state == S_SCAN) && !hit_now && (addr < fill);
  assign wr_en      = q_pop && (q_op.kind == OP_STORE);
  assign full_table = (fill == CNT_W'(TABLE_DEPTH));

  assign write_pointer_next = (write_pointer == IDX_W'(TABLE_DEPTH - 1)) ?
                              '0 : write_pointer + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_ips[write_pointer]  <= q_op.ip;
      entry_macs[write_pointer] <= q_op.mac;
    end
    if (rd_en) begin
      rd_ip  <= entry_ips[addr[IDX_W-1:0]];
      rd_mac <= entry_macs[addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      write_pointer <= '0;
      fill          <= '0;
      addr          <= '0;
      rd_pend       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            // a lookup holds its result word until the scan ends
            res_valid        <= (q_op.kind != OP_LOOKUP);
            reply_valid      <= (q_op.kind == OP_REPLY);
            reply_target_mac <= (q_op.kind == OP_REPLY) ? q_op.mac : '0;
            reply_target_ip  <= (q_op.kind == OP_REPLY) ? q_op.ip : '0;
            lookup_hit       <= 1'b0;
            lookup_mac       <= '0;
            unique case (q_op.kind)
              OP_STORE: begin
                write_pointer <= write_pointer_next;
                if (!full_table) begin
                  fill <= fill + CNT_W'(1);
                end
              end
              OP_LOOKUP: begin
                state   <= S_SCAN;
                key     <= q_op.ip;
                addr    <= '0;
                rd_pend <= 1'b0;
              end
              OP_REPLY, OP_NONE: begin
              end
              default: begin
              end
            endcase
          end else if (res_valid && !out_stall) begin
            res_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            state      <= S_IDLE;
            rd_pend    <= 1'b0;
            res_valid  <= 1'b1;
            lookup_hit <= 1'b1;
            lookup_mac <= rd_mac;
          end else if (rd_en) begin
            addr    <= addr + CNT_W'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              // entries past the fill count are treated as ip 0 and mac 0
              state      <= S_IDLE;
              res_valid  <= 1'b1;
              lookup_hit <= (key == '0) && !full_table;
              lookup_mac <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_tracks_pointer: assert property (@(posedge clk) disable iff (rst)
    !full_table |-> (CNT_W'(write_pointer) == fill))
    else $error("fill count and write pointer disagree before wrap");

  a_scan_within_fill: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (addr < fill))
    else $error("scan read past written entries");

  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(reply_valid && lookup_hit))
    else $error("result word carries both reply and lookup hit");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |-> !q_pop)
    else $error("operation taken while result word is stalled");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the arp responder and address cache. A short
// table of directed words covers the corner cases, then random traffic from a
// small ip pool drives requests, table stores and lookups under several
// register settings and stall patterns. Every result word is compared, field
// by field, against an in-bench prediction of the table and responder.
// ----------------------------------------------------------------------------
module testbench;
  import arpc_pkg::*;

  localparam int TABLE_SIZE   = TABLE_DEPTH_DEF;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int RANDOM_WORDS = 1150;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 12;

  localparam logic             REG_OWN_MAC = 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [OPC_W-1:0] OPC_ZERO    = 16'd0;
  localparam logic [OPC_W-1:0] OPC_THREE   = 16'd3;
  localparam logic [OPC_W-1:0] OPC_ONES    = 16'hFFFF;

  localparam logic [IP_W-1:0]  DIR_OWN_IP  = 32'hC0A8_0A01;
  localparam logic [MAC_W-1:0] DIR_OWN_MAC = 48'h0200_0000_0001;
  localparam logic [IP_W-1:0]  IP_ONES     = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_ONES    = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FIX_PREDICT,
    FIX_ZERO,
    FIX_REPLY,
    FIX_HIT_ZERO
  } fixed_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [OPC_W-1:0] opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
    logic [IP_W-1:0]  table_ip;
    logic [MAC_W-1:0] entry_mac;
  } arp_word_t;

  typedef struct {
    logic             reply_valid;
    logic [MAC_W-1:0] reply_mac;
    logic [IP_W-1:0]  reply_ip;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
  } arp_result_t;

  typedef struct {
    fixed_t    fixed;
    arp_word_t word;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = REG_OWN_IP;
  logic [MAC_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] cmd = CMD_PACKET;
  logic [OPC_W-1:0] opcode = '0;
  logic [MAC_W-1:0] sender_mac = '0;
  logic [IP_W-1:0]  sender_ip = '0;
  logic [IP_W-1:0]  target_ip = '0;
  logic [IP_W-1:0]  table_ip = '0;
  logic [MAC_W-1:0] entry_mac = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             reply_valid;
  logic [MAC_W-1:0] reply_target_mac;
  logic [IP_W-1:0]  reply_target_ip;
  logic             lookup_hit;
  logic [MAC_W-1:0] lookup_mac;

  // shadow of the cache and the registers
  bit [IP_W-1:0]  ip_table [TABLE_SIZE];
  bit [MAC_W-1:0] mac_table [TABLE_SIZE];
  int unsigned    store_ptr = 0;
  bit [IP_W-1:0]  own_ip_reg = '0;
  bit [MAC_W-1:0] own_mac_reg = '0;

  arp_result_t    expected_responses[$];
  directed_row_t  directed_rows[$];
  bit [IP_W-1:0]  ip_pool [POOL_SIZE];
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;

  arp_responder_and_cache #(.TABLE_DEPTH(TABLE_SIZE)) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cmd              (cmd),
    .opcode           (opcode),
    .sender_mac       (sender_mac),
    .sender_ip        (sender_ip),
    .target_ip        (target_ip),
    .table_ip         (table_ip),
    .entry_mac        (entry_mac),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .reply_valid      (reply_valid),
    .reply_target_mac (reply_target_mac),
    .reply_target_ip  (reply_target_ip),
    .lookup_hit       (lookup_hit),
    .lookup_mac       (lookup_mac)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void store_entry(bit [IP_W-1:0] ip, bit [MAC_W-1:0] mac);
    ip_table[store_ptr]  = ip;
    mac_table[store_ptr] = mac;
    store_ptr = (store_ptr == TABLE_SIZE - 1) ? 0 : store_ptr + 1;
  endfunction

  function automatic arp_result_t predict_arp_response(arp_word_t w);
    arp_result_t r;
    bit          found;
    r.reply_valid = 1'b0;
    r.reply_mac   = '0;
    r.reply_ip    = '0;
    r.hit         = 1'b0;
    r.hit_mac     = '0;
    found = 1'b0;
    case (w.cmd)
      CMD_PACKET: begin
        if (w.opcode == OPC_REQUEST) begin
          if (own_ip_reg != '0 && own_ip_reg == w.target_ip) begin
            r.reply_valid = 1'b1;
            r.reply_mac   = w.sender_mac;
            r.reply_ip    = w.sender_ip;
          end
        end else if (w.opcode == OPC_REPLY) begin
          store_entry(w.sender_ip, w.sender_mac);
        end
      end
      CMD_ADD: begin
        store_entry(w.table_ip, w.entry_mac);
      end
      CMD_LOOKUP: begin
        // first match from index 0 wins
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (!found && ip_table[i] == w.table_ip) begin
            found     = 1'b1;
            r.hit     = 1'b1;
            r.hit_mac = mac_table[i];
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic bit [MAC_W-1:0] rand_mac();
    bit [63:0] v;
    v = {$urandom, $urandom};
    return v[MAC_W-1:0];
  endfunction

  function automatic bit [IP_W-1:0] pick_ip();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65)
      return ip_pool[$urandom_range(POOL_SIZE - 1)];
    if (pick < 75)
      return own_ip_reg;
    return $urandom;
  endfunction

  function automatic void add_row(fixed_t kind, logic [CMD_W-1:0] c, logic [OPC_W-1:0] opc,
                                  logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
                                  logic [IP_W-1:0] tip, logic [IP_W-1:0] tbl,
                                  logic [MAC_W-1:0] emac);
    directed_row_t r;
    r.fixed           = kind;
    r.word.cmd        = c;
    r.word.opcode     = opc;
    r.word.sender_mac = smac;
    r.word.sender_ip  = sip;
    r.word.target_ip  = tip;
    r.word.table_ip   = tbl;
    r.word.entry_mac  = emac;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(arp_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= w.cmd;
    opcode     <= w.opcode;
    sender_mac <= w.sender_mac;
    sender_ip  <= w.sender_ip;
    target_ip  <= w.target_ip;
    table_ip   <= w.table_ip;
    entry_mac  <= w.entry_mac;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    cfg_write <= 1'b1;
    cfg_index <= REG_OWN_IP;
    cfg_data  <= {{(MAC_W - IP_W){1'b0}}, ip};
    @(posedge clk);
    cfg_index <= REG_OWN_MAC;
    cfg_data  <= mac;
    @(posedge clk);
    cfg_write <= 1'b0;
    own_ip_reg  = ip;
    own_mac_reg = mac;
  endtask

  task automatic run_random_phase(int unsigned words, int unsigned send_pct,
                                  int unsigned recv_pct);
    arp_word_t   w;
    int unsigned sent;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      w.cmd = (pick < 40) ? CMD_PACKET : (pick < 72) ? CMD_ADD :
              (pick < 96) ? CMD_LOOKUP : CMD_UNUSED;
      pick = $urandom_range(99);
      w.opcode = (pick < 45) ? OPC_REQUEST : (pick < 85) ? OPC_REPLY :
                 OPC_W'($urandom_range(16'hFFFF));
      w.sender_mac = rand_mac();
      w.sender_ip  = pick_ip();
      w.target_ip  = ($urandom_range(99) < 55) ? own_ip_reg : pick_ip();
      w.table_ip   = pick_ip();
      w.entry_mac  = rand_mac();
      send_word(w);
      expected_responses.push_back(predict_arp_response(w));
      sent++;
      // now and then hold off until the cache has answered everything
      if ($urandom_range(199) == 0)
        wait_for_drain();
    end
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("arp_responder_and_cache regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    arp_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: reply %b %h %h hit %b %h",
                   reply_valid, reply_target_mac, reply_target_ip, lookup_hit, lookup_mac);
      end else begin
        want = expected_responses.pop_front();
        if (reply_valid !== want.reply_valid || reply_target_mac !== want.reply_mac ||
            reply_target_ip !== want.reply_ip || lookup_hit !== want.hit ||
            lookup_mac !== want.hit_mac) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected reply %b %h %h hit %b %h, got reply %b %h %h hit %b %h",
                     want.reply_valid, want.reply_mac, want.reply_ip, want.hit, want.hit_mac,
                     reply_valid, reply_target_mac, reply_target_ip, lookup_hit, lookup_mac);
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    arp_result_t   want;
    ip_pool[0] = '0;
    ip_pool[1] = IP_ONES;
    for (int i = 2; i < POOL_SIZE; i++)
      ip_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 70;
    write_config(DIR_OWN_IP, DIR_OWN_MAC);

    // empty table: every entry holds ip 0 with mac 0
    add_row(FIX_HIT_ZERO, CMD_LOOKUP, OPC_REQUEST, MAC_ONES, IP_ONES, DIR_OWN_IP, '0, MAC_ONES);
    add_row(FIX_ZERO, CMD_LOOKUP, OPC_ZERO, '0, '0, '0, IP_ONES, '0);
    add_row(FIX_REPLY, CMD_PACKET, OPC_REQUEST, MAC_ONES, IP_ONES, DIR_OWN_IP, IP_ONES, '0);
    add_row(FIX_REPLY, CMD_PACKET, OPC_REQUEST, '0, '0, DIR_OWN_IP, '0, MAC_ONES);
    add_row(FIX_ZERO, CMD_PACKET, OPC_REQUEST, 48'h0011_2233_4455, 32'h0A00_0009,
            DIR_OWN_IP ^ 32'd1, DIR_OWN_IP, '0);
    add_row(FIX_ZERO, CMD_PACKET, OPC_REQUEST, 48'h0011_2233_4466, 32'h0A00_000A, '0, '0, '0);
    add_row(FIX_ZERO, CMD_PACKET, OPC_REPLY, 48'hAAAA_AAAA_AAAA, 32'h0A00_0005,
            DIR_OWN_IP, '0, '0);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_ZERO, '0, '0, '0, 32'h0A00_0005, '0);
    add_row(FIX_ZERO, CMD_ADD, OPC_ZERO, '0, '0, '0, IP_ONES, MAC_ONES);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_ONES, MAC_ONES, IP_ONES, IP_ONES, IP_ONES, MAC_ONES);
    // a stored ip 0 shadows the never-written entries behind it
    add_row(FIX_ZERO, CMD_ADD, OPC_ZERO, '0, '0, '0, '0, 48'h1234_5678_9ABC);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_ZERO, '0, '0, '0, '0, '0);
    add_row(FIX_ZERO, CMD_ADD, OPC_ZERO, '0, '0, '0, 32'h0A00_0005, 48'h5555_5555_5555);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_ZERO, '0, '0, '0, 32'h0A00_0005, '0);
    add_row(FIX_ZERO, CMD_PACKET, OPC_ZERO, MAC_ONES, IP_ONES, DIR_OWN_IP, IP_ONES, MAC_ONES);
    add_row(FIX_ZERO, CMD_PACKET, OPC_THREE, MAC_ONES, IP_ONES, DIR_OWN_IP, '0, '0);
    add_row(FIX_ZERO, CMD_PACKET, OPC_ONES, MAC_ONES, IP_ONES, DIR_OWN_IP, '0, MAC_ONES);
    add_row(FIX_ZERO, CMD_UNUSED, OPC_REQUEST, MAC_ONES, IP_ONES, DIR_OWN_IP, '0, MAC_ONES);
    add_row(FIX_ZERO, CMD_ADD, OPC_REQUEST, MAC_ONES, IP_ONES, DIR_OWN_IP, DIR_OWN_IP, '0);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_REQUEST, MAC_ONES, IP_ONES, DIR_OWN_IP,
            DIR_OWN_IP, MAC_ONES);
    add_row(FIX_PREDICT, CMD_PACKET, OPC_REQUEST, 48'h0A1B_2C3D_4E5F, 32'hC0A8_0A63,
            DIR_OWN_IP, '0, '0);
    add_row(FIX_ZERO, CMD_PACKET, OPC_REPLY, 48'hDEAD_BEEF_0001, DIR_OWN_IP, '0, '0, '0);
    add_row(FIX_PREDICT, CMD_LOOKUP, OPC_ZERO, '0, '0, '0, DIR_OWN_IP, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.word);
      want = predict_arp_response(row.word);
      if (row.fixed != FIX_PREDICT) begin
        want.reply_valid = (row.fixed == FIX_REPLY);
        want.reply_mac   = (row.fixed == FIX_REPLY) ? row.word.sender_mac : '0;
        want.reply_ip    = (row.fixed == FIX_REPLY) ? row.word.sender_ip : '0;
        want.hit         = (row.fixed == FIX_HIT_ZERO);
        want.hit_mac     = '0;
      end
      expected_responses.push_back(want);
    end
    wait_for_drain();

    // own ip unset: requests are never answered
    write_config('0, rand_mac());
    run_random_phase(RANDOM_WORDS / 4, 13, 70);
    write_config(IP_ONES, MAC_ONES);
    run_random_phase(RANDOM_WORDS / 4, 70, 13);
    write_config($urandom, '0);
    run_random_phase(RANDOM_WORDS / 4, 0, 0);
    write_config(ip_pool[2], rand_mac());
    run_random_phase(RANDOM_WORDS / 4, 0, 0);

    repeat (TABLE_SIZE + 8) @(posedge clk);
    if (mismatches == 0 && expected_responses.size() == 0)
      $display("arp_responder_and_cache regression: pass");
    else
      $display("arp_responder_and_cache regression: fail");
    $finish;
  end

endmodule
